FILE: rtl/core/kseq_pkg.sv
// Package for the terminal key sequence decoder.
// Holds the parse modes, key kinds, result record and the idle-state byte decoder.
// No dependencies.
`default_nettype none

package kseq_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [7:0] BYTE_ESC = 8'h1b;
  localparam logic [7:0] BYTE_DEL = 8'h7f;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_UTF8 = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_SS3  = 3'd3,
    MODE_CSI  = 3'd4
  } mode_e;

  typedef enum logic [4:0] {
    KEY_NONE   = 5'd0,
    KEY_CHAR   = 5'd1,
    KEY_ENTER  = 5'd2,
    KEY_TAB    = 5'd3,
    KEY_BS     = 5'd4,
    KEY_ESCAPE = 5'd5,
    KEY_UP     = 5'd6,
    KEY_DOWN   = 5'd7,
    KEY_RIGHT  = 5'd8,
    KEY_LEFT   = 5'd9,
    KEY_HOME   = 5'd10,
    KEY_END    = 5'd11,
    KEY_INSERT = 5'd12,
    KEY_DELETE = 5'd13,
    KEY_PGUP   = 5'd14,
    KEY_PGDN   = 5'd15,
    KEY_FUNC   = 5'd16
  } key_e;

  typedef struct packed {
    key_e             kind;
    logic [CodeW-1:0] code;
    logic             last;
  } result_t;

  // Outcome of decoding one byte from the idle mode.
  typedef struct packed {
    logic             hit;
    result_t          res;
    mode_e            mode;
    logic             load;
    logic [CodeW-1:0] acc;
    logic [1:0]       rem;
  } idle_dec_t;

  function automatic idle_dec_t idle_decode(logic [7:0] b, logic eob);
    idle_dec_t d;
    d          = '0;
    d.mode     = MODE_IDLE;
    d.res.kind = KEY_NONE;
    if (b == BYTE_ESC) begin
      if (eob) begin
        d.hit      = 1'b1;
        d.res.kind = KEY_ESCAPE;
      end else begin
        d.mode = MODE_ESC;
      end
    end else if (b == BYTE_CR || b == BYTE_LF) begin
      d.hit      = 1'b1;
      d.res.kind = KEY_ENTER;
    end else if (b == BYTE_TAB) begin
      d.hit      = 1'b1;
      d.res.kind = KEY_TAB;
    end else if (b == BYTE_DEL || b == BYTE_BS) begin
      d.hit      = 1'b1;
      d.res.kind = KEY_BS;
    end else if (b[7:5] == 3'b110) begin
      d.load = 1'b1;
      d.acc  = {16'd0, b[4:0]};
      d.rem  = 2'd1;
      d.mode = MODE_UTF8;
    end else if (b[7:4] == 4'b1110) begin
      d.load = 1'b1;
      d.acc  = {17'd0, b[3:0]};
      d.rem  = 2'd2;
      d.mode = MODE_UTF8;
    end else if (b[7:3] == 5'b11110) begin
      d.load = 1'b1;
      d.acc  = {18'd0, b[2:0]};
      d.rem  = 2'd3;
      d.mode = MODE_UTF8;
    end else begin
      // Plain bytes and invalid UTF-8 lead bytes are one-byte characters.
      d.hit      = 1'b1;
      d.res.kind = KEY_CHAR;
      d.res.code = {13'd0, b};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/terminal_key_sequence_decoder_top.sv
// Top level of the terminal key sequence decoder.
// Instantiates kseq_decode and kseq_rfifo; uses kseq_pkg.
//
//   channel  valid        stall         payload
//   input    in_valid_i   in_stall_o    data_byte_i, buffer_end_i
//   output   out_valid_o  out_stall_i   key_kind_o, key_code_o, run_last_o
//
// One item is accepted per cycle while in_stall_o is low; its results enter the result queue
// at the accepting edge and are shown from there, one per cycle while out_stall_i is low.
// The rate is one item per cycle, set by the single output port when every item gives one
// result and no stall holds the flow. Reset returns the parser to idle and empties the
// queue. in_stall_o rises while the queue has fewer than two free entries.
`default_nettype none

module terminal_key_sequence_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        buffer_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       key_kind_o,
  output logic [20:0]      key_code_o,
  output logic             run_last_o
);
  import kseq_pkg::*;

  logic       accept;
  logic       room;
  logic [1:0] push_n;
  result_t    res0, res1, head;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  kseq_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .push_n_o     (push_n),
    .res0_o       (res0),
    .res1_o       (res1)
  );

  kseq_rfifo u_rfifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (accept ? push_n : 2'd0),
    .res0_i      (res0),
    .res1_i      (res1),
    .pop_stall_i (out_stall_i),
    .room_o      (room),
    .valid_o     (out_valid_o),
    .head_o      (head)
  );

  assign key_kind_o = head.kind;
  assign key_code_o = head.code;
  assign run_last_o = head.last;

endmodule

`default_nettype wire

FILE: rtl/core/kseq_decode.sv
// Parser state registers and the single-pass byte decoder.
// Produces zero, one or two results per accepted byte; uses kseq_pkg.
`default_nettype none

module kseq_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              buffer_end_i,
  output logic [1:0]             push_n_o,
  output kseq_pkg::result_t      res0_o,
  output kseq_pkg::result_t      res1_o
);
  import kseq_pkg::*;

  mode_e             mode_q, mode_d;
  logic [1:0]        rem_q, rem_d;
  logic [CodeW-1:0]  acc_q, acc_d;
  logic [31:0]       value_q, value_d;
  logic [31:0]       first_q, first_d;
  logic              seen_q, seen_d;

  idle_dec_t         idec;
  logic [31:0]       p_eff;
  logic [CodeW-1:0]  acc_shift;
  logic [1:0]        rem_dec;
  logic [31:0]       value_x10;

  // Keys shared by SS3 and CSI finals.
  function automatic result_t letter_key(logic [7:0] b);
    result_t r;
    r      = '0;
    r.kind = KEY_NONE;
    case (b)
      8'h41:   r.kind = KEY_UP;
      8'h42:   r.kind = KEY_DOWN;
      8'h43:   r.kind = KEY_RIGHT;
      8'h44:   r.kind = KEY_LEFT;
      8'h48:   r.kind = KEY_HOME;
      8'h46:   r.kind = KEY_END;
      8'h50, 8'h51, 8'h52, 8'h53: begin
        r.kind = KEY_FUNC;
        r.code = {19'd0, b[1:0]} + 21'd1;
      end
      default: r.kind = KEY_NONE;
    endcase
    return r;
  endfunction

  // Key selected by the first numeric parameter of an ESC [ n ~ sequence.
  function automatic result_t tilde_key(logic [31:0] p);
    result_t r;
    r      = '0;
    r.kind = KEY_NONE;
    if (p[31:5] == '0) begin
      case (p[4:0])
        5'd1, 5'd7: r.kind = KEY_HOME;
        5'd2:       r.kind = KEY_INSERT;
        5'd3:       r.kind = KEY_DELETE;
        5'd4, 5'd8: r.kind = KEY_END;
        5'd5:       r.kind = KEY_PGUP;
        5'd6:       r.kind = KEY_PGDN;
        5'd11, 5'd12, 5'd13, 5'd14, 5'd15: begin
          r.kind = KEY_FUNC;
          r.code = {16'd0, 5'(p[4:0] - 5'd10)};
        end
        5'd17, 5'd18, 5'd19, 5'd20, 5'd21: begin
          r.kind = KEY_FUNC;
          r.code = {16'd0, 5'(p[4:0] - 5'd11)};
        end
        5'd23, 5'd24: begin
          r.kind = KEY_FUNC;
          r.code = {16'd0, 5'(p[4:0] - 5'd12)};
        end
        default: r.kind = KEY_NONE;
      endcase
    end
    return r;
  endfunction

  assign idec      = idle_decode(data_byte_i, buffer_end_i);
  assign acc_shift = {acc_q[CodeW-7:0], data_byte_i[5:0]};
  assign rem_dec   = rem_q - 2'd1;
  assign value_x10 = {value_q[28:0], 3'b000} + {value_q[30:0], 1'b0}
                   + {28'd0, 4'(data_byte_i[3:0])};
  // A zero first parameter counts as absent at the final byte.
  assign p_eff     = (first_q == '0 && seen_q) ? value_q : first_q;

  always_comb begin
    mode_d   = mode_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    value_d  = value_q;
    first_d  = first_q;
    seen_d   = seen_q;
    push_n_o = 2'd0;
    res0_o   = '0;
    res1_o   = '0;
    res0_o.kind = KEY_NONE;
    res1_o.kind = KEY_NONE;

    unique case (mode_q)
      MODE_UTF8: begin
        acc_d = acc_shift;
        rem_d = rem_dec;
        if (rem_dec == 2'd0) begin
          res0_o.kind = KEY_CHAR;
          res0_o.code = acc_shift;
          res0_o.last = 1'b1;
          push_n_o    = 2'd1;
          mode_d      = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        if (data_byte_i == 8'h4f) begin
          mode_d = MODE_SS3;
        end else if (data_byte_i == 8'h5b) begin
          mode_d  = MODE_CSI;
          value_d = '0;
          first_d = '0;
          seen_d  = 1'b0;
        end else begin
          // The pending escape is reported, then this byte starts afresh.
          res0_o.kind = KEY_ESCAPE;
          mode_d      = idec.mode;
          if (idec.load) begin
            acc_d = idec.acc;
            rem_d = idec.rem;
          end
          if (idec.hit) begin
            res1_o      = idec.res;
            res1_o.last = 1'b1;
            push_n_o    = 2'd2;
          end else begin
            res0_o.last = 1'b1;
            push_n_o    = 2'd1;
          end
        end
      end
      MODE_SS3: begin
        res0_o      = letter_key(data_byte_i);
        res0_o.last = 1'b1;
        push_n_o    = 2'd1;
        mode_d      = MODE_IDLE;
      end
      MODE_CSI: begin
        if (data_byte_i == 8'h3b) begin
          if (first_q == '0) first_d = value_q;
          value_d = '0;
          seen_d  = 1'b0;
        end else if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
          value_d = value_x10;
          seen_d  = 1'b1;
        end else begin
          first_d = p_eff;
          if (data_byte_i == 8'h7e) res0_o = tilde_key(p_eff);
          else                      res0_o = letter_key(data_byte_i);
          res0_o.last = 1'b1;
          push_n_o    = 2'd1;
          mode_d      = MODE_IDLE;
        end
      end
      default: begin
        mode_d = idec.mode;
        if (idec.load) begin
          acc_d = idec.acc;
          rem_d = idec.rem;
        end
        if (idec.hit) begin
          res0_o      = idec.res;
          res0_o.last = 1'b1;
          push_n_o    = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      rem_q   <= '0;
      acc_q   <= '0;
      value_q <= '0;
      first_q <= '0;
      seen_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      value_q <= value_d;
      first_q <= first_d;
      seen_q  <= seen_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kseq_rfifo.sv
// Four-entry result queue taking up to two results per cycle, giving one.
// Uses the result record from kseq_pkg.
`default_nettype none

module kseq_rfifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [1:0]        push_n_i,
  input  wire kseq_pkg::result_t res0_i,
  input  wire kseq_pkg::result_t res1_i,
  input  wire logic              pop_stall_i,
  output logic                   room_o,
  output logic                   valid_o,
  output kseq_pkg::result_t      head_o
);
  import kseq_pkg::*;

  result_t    entries_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 3'd0);
  assign head_o  = entries_q[rd_ptr_q];
  assign pop     = valid_o && !pop_stall_i;
  // Two free entries are needed since one item may cause two results.
  assign room_o  = (count_q <= 3'd2);
  assign count_d = count_q + {1'b0, push_n_i} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) entries_q[wr_ptr_q] <= res0_i;
    if (push_n_i == 2'd2) entries_q[wr_ptr_q + 2'd1] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n_i;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_terminal_key_sequence_decoder_top.sv
// Testbench for terminal_key_sequence_decoder_top: directed and random byte streams.
// Expected key events come from an in-bench decoder model and are checked in order.
// Depends on kseq_pkg and the decoder RTL.
`default_nettype none

module tb_terminal_key_sequence_decoder_top;
  import kseq_pkg::*;

  localparam int CLK_PERIOD = 4;

  localparam logic [7:0] CH_SS3    = "O";
  localparam logic [7:0] CH_CSI    = "[";
  localparam logic [7:0] CH_SEP    = ";";
  localparam logic [7:0] CH_TILDE  = "~";
  localparam logic [7:0] DIGIT_0   = "0";
  localparam logic [7:0] DIGIT_9   = "9";
  localparam logic [7:0] FIN_UP    = "A";
  localparam logic [7:0] FIN_DOWN  = "B";
  localparam logic [7:0] FIN_RIGHT = "C";
  localparam logic [7:0] FIN_LEFT  = "D";
  localparam logic [7:0] FIN_HOME  = "H";
  localparam logic [7:0] FIN_END   = "F";
  localparam logic [7:0] FIN_F1    = "P";
  localparam logic [7:0] FIN_F2    = "Q";
  localparam logic [7:0] FIN_F3    = "R";
  localparam logic [7:0] FIN_F4    = "S";

  // First parameter values understood before a tilde.
  localparam logic [31:0] VT_HOME     = 32'd1;
  localparam logic [31:0] VT_INSERT   = 32'd2;
  localparam logic [31:0] VT_DELETE   = 32'd3;
  localparam logic [31:0] VT_END      = 32'd4;
  localparam logic [31:0] VT_PGUP     = 32'd5;
  localparam logic [31:0] VT_PGDN     = 32'd6;
  localparam logic [31:0] VT_HOME_ALT = 32'd7;
  localparam logic [31:0] VT_END_ALT  = 32'd8;
  localparam logic [31:0] VT_F1       = 32'd11;
  localparam logic [31:0] VT_F5       = 32'd15;
  localparam logic [31:0] VT_F6       = 32'd17;
  localparam logic [31:0] VT_F10      = 32'd21;
  localparam logic [31:0] VT_F11      = 32'd23;
  localparam logic [31:0] VT_F12      = 32'd24;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        buffer_end;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  key_kind;
  logic [20:0] key_code;
  logic        run_last;

  // Decoder model state.
  mode_e       dec_mode;
  logic [1:0]  dec_left;
  logic [20:0] dec_acc;
  logic [31:0] dec_val;
  logic [31:0] dec_first;
  logic        dec_seen;

  result_t     expected_keys[$];
  int          error_count = 0;
  int          sent_items = 0;
  bit          tx_gap_on = 1'b0;
  bit          rx_gap_on = 1'b0;
  int          hold_req = 0;

  terminal_key_sequence_decoder_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .buffer_end_i (buffer_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .key_kind_o   (key_kind),
    .key_code_o   (key_code),
    .run_last_o   (run_last)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic result_t make_key(input key_e kind, input logic [20:0] code);
    result_t r;
    r.kind = kind;
    r.code = code;
    r.last = 1'b0;
    return r;
  endfunction

  // Decodes a byte as if the parser were idle and updates the model state.
  function automatic void decode_from_idle(input logic [7:0] b, input logic eob,
                                           output logic hit, output result_t r);
    hit      = 1'b1;
    r        = make_key(KEY_NONE, '0);
    dec_mode = MODE_IDLE;
    if (b == BYTE_ESC) begin
      if (eob) begin
        r.kind = KEY_ESCAPE;
      end else begin
        hit      = 1'b0;
        dec_mode = MODE_ESC;
      end
    end else if (b == BYTE_CR || b == BYTE_LF) begin
      r.kind = KEY_ENTER;
    end else if (b == BYTE_TAB) begin
      r.kind = KEY_TAB;
    end else if (b == BYTE_DEL || b == BYTE_BS) begin
      r.kind = KEY_BS;
    end else if (b >= 8'hc0 && b <= 8'hdf) begin
      hit      = 1'b0;
      dec_acc  = 21'(b & 8'h1f);
      dec_left = 2'd1;
      dec_mode = MODE_UTF8;
    end else if (b >= 8'he0 && b <= 8'hef) begin
      hit      = 1'b0;
      dec_acc  = 21'(b & 8'h0f);
      dec_left = 2'd2;
      dec_mode = MODE_UTF8;
    end else if (b >= 8'hf0 && b <= 8'hf7) begin
      hit      = 1'b0;
      dec_acc  = 21'(b & 8'h07);
      dec_left = 2'd3;
      dec_mode = MODE_UTF8;
    end else begin
      r = make_key(KEY_CHAR, 21'(b));
    end
  endfunction

  // Works out the key events of one accepted byte and queues them.
  function automatic void predict_keys(input logic [7:0] b, input logic eob);
    result_t     got[$];
    result_t     r;
    logic        hit;
    key_e        kind;
    logic [20:0] code;
    logic [31:0] p;
    case (dec_mode)
      MODE_UTF8: begin
        dec_acc  = {dec_acc[14:0], b[5:0]};
        dec_left = dec_left - 2'd1;
        if (dec_left == 2'd0) begin
          got.push_back(make_key(KEY_CHAR, dec_acc));
          dec_mode = MODE_IDLE;
        end
      end
      MODE_ESC: begin
        if (b == CH_SS3) begin
          dec_mode = MODE_SS3;
        end else if (b == CH_CSI) begin
          dec_mode  = MODE_CSI;
          dec_val   = '0;
          dec_first = '0;
          dec_seen  = 1'b0;
        end else begin
          got.push_back(make_key(KEY_ESCAPE, '0));
          decode_from_idle(b, eob, hit, r);
          if (hit) got.push_back(r);
        end
      end
      MODE_SS3: begin
        kind = KEY_NONE;
        code = '0;
        if (b >= FIN_F1 && b <= FIN_F4) begin
          kind = KEY_FUNC;
          code = 21'(b - FIN_F1) + 21'd1;
        end else if (b == FIN_HOME)  kind = KEY_HOME;
        else if (b == FIN_END)       kind = KEY_END;
        else if (b == FIN_UP)        kind = KEY_UP;
        else if (b == FIN_DOWN)      kind = KEY_DOWN;
        else if (b == FIN_RIGHT)     kind = KEY_RIGHT;
        else if (b == FIN_LEFT)      kind = KEY_LEFT;
        got.push_back(make_key(kind, code));
        dec_mode = MODE_IDLE;
      end
      MODE_CSI: begin
        if (b == CH_SEP) begin
          if (dec_first == '0) dec_first = dec_val;
          dec_val  = '0;
          dec_seen = 1'b0;
        end else if (b >= DIGIT_0 && b <= DIGIT_9) begin
          dec_val  = dec_val * 32'd10 + 32'(b - DIGIT_0);
          dec_seen = 1'b1;
        end else begin
          // A zero first parameter counts as absent.
          if (dec_first == '0 && dec_seen) dec_first = dec_val;
          p    = dec_first;
          kind = KEY_NONE;
          code = '0;
          if (b == FIN_UP)                     kind = KEY_UP;
          else if (b == FIN_DOWN)              kind = KEY_DOWN;
          else if (b == FIN_RIGHT)             kind = KEY_RIGHT;
          else if (b == FIN_LEFT)              kind = KEY_LEFT;
          else if (b == FIN_HOME)              kind = KEY_HOME;
          else if (b == FIN_END)               kind = KEY_END;
          else if (b >= FIN_F1 && b <= FIN_F4) begin
            kind = KEY_FUNC;
            code = 21'(b - FIN_F1) + 21'd1;
          end else if (b == CH_TILDE) begin
            if (p == VT_HOME || p == VT_HOME_ALT)    kind = KEY_HOME;
            else if (p == VT_INSERT)                 kind = KEY_INSERT;
            else if (p == VT_DELETE)                 kind = KEY_DELETE;
            else if (p == VT_END || p == VT_END_ALT) kind = KEY_END;
            else if (p == VT_PGUP)                   kind = KEY_PGUP;
            else if (p == VT_PGDN)                   kind = KEY_PGDN;
            else if (p >= VT_F1 && p <= VT_F5) begin
              kind = KEY_FUNC;
              code = 21'(p - VT_F1) + 21'd1;
            end else if (p >= VT_F6 && p <= VT_F10) begin
              kind = KEY_FUNC;
              code = 21'(p - VT_F6) + 21'd6;
            end else if (p == VT_F11 || p == VT_F12) begin
              kind = KEY_FUNC;
              code = 21'(p - VT_F11) + 21'd11;
            end
          end
          got.push_back(make_key(kind, code));
          dec_mode = MODE_IDLE;
        end
      end
      default: begin
        decode_from_idle(b, eob, hit, r);
        if (hit) got.push_back(r);
      end
    endcase
    if (got.size() != 0) got[got.size() - 1].last = 1'b1;
    foreach (got[i]) expected_keys.push_back(got[i]);
  endfunction

  function automatic logic end_flag(input int one_in);
    return $urandom_range(0, one_in - 1) == 0;
  endfunction

  function automatic logic [7:0] random_final();
    case ($urandom_range(0, 9))
      0:       return FIN_UP;
      1:       return FIN_DOWN;
      2:       return FIN_RIGHT;
      3:       return FIN_LEFT;
      4:       return FIN_HOME;
      5:       return FIN_END;
      6:       return FIN_F1;
      7:       return FIN_F2;
      8:       return FIN_F3;
      default: return FIN_F4;
    endcase
  endfunction

  // Offers one item, starting and ending at a falling edge. Valid stays high for
  // the next call, so back-to-back items keep the channel busy.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    if (tx_gap_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    buffer_end <= eob;
    do @(posedge clk_i); while (in_stall);
    predict_keys(b, eob);
    sent_items++;
    @(negedge clk_i);
  endtask

  // Mostly well-formed key sequences with random content, some raw noise.
  task automatic send_random_sequence();
    int              pick;
    int              len;
    int              nparm;
    int              i;
    longint unsigned v;
    logic [7:0]      lead;
    logic [7:0]      dig[$];
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_byte(8'($urandom_range(0, 255)), end_flag(3));
    end else if (pick < 30) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       lead = {3'b110, 5'($urandom)};
        3:       lead = {4'b1110, 4'($urandom)};
        default: lead = {5'b11110, 3'($urandom)};
      endcase
      send_byte(lead, end_flag(6));
      repeat (len - 1) begin
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), end_flag(4));
        else send_byte({2'b10, 6'($urandom)}, end_flag(4));
      end
    end else if (pick < 40) begin
      send_byte(BYTE_ESC, end_flag(4));
      send_byte(8'($urandom), end_flag(2));
    end else if (pick < 45) begin
      send_byte(BYTE_ESC, 1'b1);
    end else if (pick < 58) begin
      send_byte(BYTE_ESC, 1'b0);
      send_byte(CH_SS3, end_flag(6));
      if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), end_flag(2));
      else send_byte(random_final(), end_flag(2));
    end else begin
      send_byte(BYTE_ESC, 1'b0);
      send_byte(CH_CSI, end_flag(6));
      nparm = $urandom_range(0, 3);
      for (i = 0; i < nparm; i++) begin
        if (i > 0) send_byte(CH_SEP, end_flag(8));
        pick = $urandom_range(0, 9);
        if (pick != 0) begin
          if (pick < 5)      v = $urandom_range(0, 30);
          else if (pick < 7) v = $urandom_range(0, 255);
          else if (pick < 8) v = $urandom;
          else v = (longint'($urandom_range(1, 20)) << 32) | $urandom_range(0, 30);
          if ($urandom_range(0, 5) == 0) send_byte(DIGIT_0, 1'b0);
          dig.delete();
          do begin
            dig.push_front(8'(v % 10));
            v = v / 10;
          end while (v != 0);
          foreach (dig[j]) send_byte(DIGIT_0 + dig[j], end_flag(10));
        end
      end
      pick = $urandom_range(0, 19);
      if (pick < 10)      send_byte(CH_TILDE, end_flag(2));
      else if (pick < 17) send_byte(random_final(), end_flag(2));
      else send_byte(8'($urandom_range(8'h20, 8'h7e)), end_flag(2));
    end
  endtask

  task automatic test_control_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(BYTE_CR, 1'b0);
    send_byte(BYTE_LF, 1'b1);
    send_byte(BYTE_TAB, 1'b0);
    send_byte(BYTE_DEL, 1'b0);
    send_byte(BYTE_BS, 1'b1);
  endtask

  task automatic test_lone_escape();
    send_byte(BYTE_ESC, 1'b1);
  endtask

  task automatic test_escape_then_byte();
    send_byte(BYTE_ESC, 1'b0);
    send_byte("q", 1'b0);
    send_byte(BYTE_ESC, 1'b0);
    send_byte(BYTE_ESC, 1'b1);
  endtask

  // Buffer end inside a code point must be ignored.
  task automatic test_utf8_with_buffer_end();
    send_byte(8'hf0, 1'b0);
    send_byte(8'h9f, 1'b1);
    send_byte(8'h98, 1'b1);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_ss3_key();
    send_byte(BYTE_ESC, 1'b0);
    send_byte(CH_SS3, 1'b0);
    send_byte(FIN_F2, 1'b0);
  endtask

  task automatic test_csi_zero_first_param();
    send_byte(BYTE_ESC, 1'b0);
    send_byte(CH_CSI, 1'b0);
    send_byte(DIGIT_0, 1'b0);
    send_byte(CH_SEP, 1'b0);
    send_byte(DIGIT_0 + 8'd2, 1'b0);
    send_byte(DIGIT_0 + 8'd4, 1'b0);
    send_byte(CH_TILDE, 1'b1);
  endtask

  task automatic test_random_streams();
    int chunk_end;
    while (sent_items < 1400) begin
      tx_gap_on = $urandom_range(0, 2) != 0;
      rx_gap_on = $urandom_range(0, 2) != 0;
      chunk_end = sent_items + 150;
      while (sent_items < chunk_end) send_random_sequence();
    end
  endtask

  // The receiver holds off at the start of a run of escape pairs, so the result queue
  // fills and the input channel has to stall.
  task automatic test_input_backpressure();
    tx_gap_on = 1'b0;
    rx_gap_on = 1'b0;
    hold_req  = 80;
    repeat (30) begin
      send_byte(BYTE_ESC, 1'b0);
      send_byte(8'($urandom_range(8'h61, 8'h7a)), end_flag(2));
    end
  endtask

  task automatic test_steady_stream();
    tx_gap_on = 1'b0;
    rx_gap_on = 1'b0;
    while (sent_items < 1850) send_random_sequence();
  endtask

  // Receiver side: random stall bursts plus the long hold-off on request.
  initial begin : rx_side
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (rx_gap_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_keys
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_keys.size() == 0) begin
        $error("unexpected key event: kind %0d code 0x%0h last %0b",
               key_kind, key_code, run_last);
        error_count++;
      end else begin
        want = expected_keys.pop_front();
        if (key_kind !== want.kind) begin
          $error("key_kind: expected %0d, got %0d", want.kind, key_kind);
          error_count++;
        end
        if (key_code !== want.code) begin
          $error("key_code: expected 0x%0h, got 0x%0h", want.code, key_code);
          error_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, run_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 400_000);
    $display("terminal_key_sequence_decoder_top: mismatch");
    $finish;
  end

  initial begin : run_tests
    int wait_cycles;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    buffer_end = 1'b0;
    dec_mode   = MODE_IDLE;
    dec_left   = '0;
    dec_acc    = '0;
    dec_val    = '0;
    dec_first  = '0;
    dec_seen   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    tx_gap_on = 1'b1;
    rx_gap_on = 1'b1;
    test_control_bytes();
    test_lone_escape();
    test_escape_then_byte();
    test_utf8_with_buffer_end();
    test_ss3_key();
    test_csi_zero_first_param();
    test_random_streams();
    test_input_backpressure();
    test_steady_stream();
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_keys.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_keys.size() != 0) begin
      $error("%0d expected key events never arrived", expected_keys.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("terminal_key_sequence_decoder_top: match");
    end else begin
      $display("terminal_key_sequence_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
